@@ rtl/bb3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Pixel and window column types, register indexes, the control state codes
// and the reciprocal table used to divide a window sum by its pixel count.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WEFF_W      = COL_W + 1;
  localparam int WID_W       = 11;
  localparam int HGT_W       = 16;
  localparam int ROW_W       = HGT_W + 1;
  localparam int CH_W        = 8;
  localparam int CSUM_W      = CH_W + 2;
  localparam int SUM_W       = CH_W + 4;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } col_sum_t;

  typedef struct packed {
    logic shift;
    logic use_top;
    logic use_bot;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_DIV
  } state_t;

  // ceil(2^RECIP_SHIFT / n); exact floor division for every window sum.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6554;
      4'd6:    r = 16'd5462;
      4'd7:    r = 16'd4682;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3641;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bb3_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_cell: one column of the 3x3 window
// Holds three pixels, passes them to the next cell on a shift and gives the
// per-channel sum of the rows that lie inside the frame.
// ----------------------------------------------------------------------------
module bb3_cell
  import bb3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire column_t    col_in,
  output column_t         col_out,
  output col_sum_t        sum_out
);

  column_t col_r;
  column_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctrl.shift) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  always_comb begin
    sum_out.red   = CSUM_W'(col_r.mid.red);
    sum_out.green = CSUM_W'(col_r.mid.green);
    sum_out.blue  = CSUM_W'(col_r.mid.blue);
    if (ctrl.use_top) begin
      sum_out.red   = sum_out.red   + CSUM_W'(col_r.top.red);
      sum_out.green = sum_out.green + CSUM_W'(col_r.top.green);
      sum_out.blue  = sum_out.blue  + CSUM_W'(col_r.top.blue);
    end
    if (ctrl.use_bot) begin
      sum_out.red   = sum_out.red   + CSUM_W'(col_r.bot.red);
      sum_out.green = sum_out.green + CSUM_W'(col_r.bot.green);
      sum_out.blue  = sum_out.blue  + CSUM_W'(col_r.bot.blue);
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

@@ rtl/box_blur_3x3_edge_average.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average: 3x3 box blur with edge-aware averaging
// Raster-order RGB pixels in, each pixel replaced by the floor of the mean of
// its in-frame 3x3 neighbours. Two line buffers share one memory; the window
// is a chain of three column cells.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    in_red_in in_green_in in_blue_in        in_valid / in_ready
//           in_padding
//  result   out_red_out out_green_out out_blue_out  out_valid / out_ready
//           out_frame_end
//  config   cfg_index cfg_wdata                     cfg_we, no wait
//
//  Each item steps through line buffer read, window shift and write-back,
//  masked sum and reciprocal multiply into the output register; an item
//  with no result ends after the shift. The memory read port sets the start.
//  The output register lets the next item enter while a result waits; the
//  multiply step holds only if a second result would overwrite it.
//  Reset is synchronous; line buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_average
  import bb3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CH_W-1:0]      in_red_in,
  input  wire logic [CH_W-1:0]      in_green_in,
  input  wire logic [CH_W-1:0]      in_blue_in,
  input  wire logic                 in_padding,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CH_W-1:0]           out_red_out,
  output logic [CH_W-1:0]           out_green_out,
  output logic [CH_W-1:0]           out_blue_out,
  output logic                      out_frame_end,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Control
  state_t state_r, state_nxt;
  logic   accept, shift_en, sum_load, out_load;

  // Configuration and position counters
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  // Line buffer memory: {above, current} per column
  column_t           unused_col;
  logic [2*$bits(pix_t)-1:0] mem [MAX_WIDTH];
  pix_t              rd_above_r, rd_cur_r;
  pix_t              pix_r;

  // Position decode
  logic [WEFF_W-1:0] w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [COL_W-1:0]  cc;
  logic [ROW_W-1:0]  cr;
  logic [WEFF_W-1:0] x_inc;
  logic              pos_valid, last;
  logic              use_top, use_bot, use_left, use_right;
  logic              use_top_r, use_bot_r, use_left_r, use_right_r;
  logic              last_r;
  logic [CNT_W-1:0]  count_r;
  logic [1:0]        n_rows, n_cols;

  // Window chain
  cell_ctrl_t        cell_ctrl;
  column_t           col_new;
  column_t           chain [2];
  col_sum_t          csum [3];
  logic [SUM_W-1:0]  sum_red_r, sum_green_r, sum_blue_r;
  logic [SUM_W-1:0]  sum_red, sum_green, sum_blue;
  logic [PROD_W-1:0] prod_red, prod_green, prod_blue;
  logic [RECIP_W-1:0] rcp;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = pos_valid ? ST_SUM : ST_IDLE;
      ST_SUM:   state_nxt = ST_DIV;
      ST_DIV:   if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    sum_load = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SHIFT: shift_en = 1'b1;
      ST_SUM:   sum_load = 1'b1;
      ST_DIV:   out_load = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[HGT_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_r);
    end
    h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
  end

  // Input capture and line buffer access
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_padding ? pix_t'('0) : pix_t'({in_red_in, in_green_in, in_blue_in});
      {rd_above_r, rd_cur_r} <= mem[col_r];
    end
  end

  // The pixel one row up moves to the row above, the new pixel becomes current.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      mem[col_r] <= {rd_cur_r, pix_r};
    end
  end

  // Centre position of the window after this item's shift
  always_comb begin
    if (col_r != '0) begin
      cc        = col_r - COL_W'(1);
      pos_valid = row_r >= ROW_W'(1);
      cr        = row_r - ROW_W'(1);
    end else begin
      cc        = COL_W'(w_eff - WEFF_W'(1));
      pos_valid = row_r >= ROW_W'(2);
      cr        = row_r - ROW_W'(2);
    end
    if (cr >= ROW_W'(h_eff)) begin
      pos_valid = 1'b0;
    end
    use_top   = cr != '0;
    use_bot   = (cr + ROW_W'(1)) < ROW_W'(h_eff);
    use_left  = cc != '0;
    use_right = (WEFF_W'(cc) + WEFF_W'(1)) < w_eff;
    last      = (cr == ROW_W'(h_eff) - ROW_W'(1)) &&
                (WEFF_W'(cc) == w_eff - WEFF_W'(1));
    n_rows    = 2'd1 + 2'(use_top) + 2'(use_bot);
    n_cols    = 2'd1 + 2'(use_left) + 2'(use_right);
  end

  always_comb begin
    x_inc   = WEFF_W'(col_r) + WEFF_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (shift_en) begin
      if (x_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = x_inc[COL_W-1:0];
      end
      if (pos_valid && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      use_top_r   <= use_top;
      use_bot_r   <= use_bot;
      use_left_r  <= use_left;
      use_right_r <= use_right;
      last_r      <= last;
      count_r     <= CNT_W'(n_rows) * CNT_W'(n_cols);
    end
  end

  // Window: cell 0 takes the newest column (right), cell 2 holds the left one.
  assign cell_ctrl.shift   = shift_en;
  assign cell_ctrl.use_top = use_top_r;
  assign cell_ctrl.use_bot = use_bot_r;
  assign col_new.top       = rd_above_r;
  assign col_new.mid       = rd_cur_r;
  assign col_new.bot       = pix_r;

  bb3_cell u_cell0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cell_ctrl),
    .col_in  (col_new),
    .col_out (chain[0]),
    .sum_out (csum[0])
  );

  bb3_cell u_cell1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cell_ctrl),
    .col_in  (chain[0]),
    .col_out (chain[1]),
    .sum_out (csum[1])
  );

  bb3_cell u_cell2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cell_ctrl),
    .col_in  (chain[1]),
    .col_out (unused_col),
    .sum_out (csum[2])
  );

  always_comb begin
    sum_red   = SUM_W'(csum[1].red);
    sum_green = SUM_W'(csum[1].green);
    sum_blue  = SUM_W'(csum[1].blue);
    if (use_left_r) begin
      sum_red   = sum_red   + SUM_W'(csum[2].red);
      sum_green = sum_green + SUM_W'(csum[2].green);
      sum_blue  = sum_blue  + SUM_W'(csum[2].blue);
    end
    if (use_right_r) begin
      sum_red   = sum_red   + SUM_W'(csum[0].red);
      sum_green = sum_green + SUM_W'(csum[0].green);
      sum_blue  = sum_blue  + SUM_W'(csum[0].blue);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_load) begin
      sum_red_r   <= sum_red;
      sum_green_r <= sum_green;
      sum_blue_r  <= sum_blue;
    end
  end

  // Division by the pixel count as a multiply by its reciprocal.
  assign rcp        = recip(count_r);
  assign prod_red   = PROD_W'(sum_red_r)   * PROD_W'(rcp);
  assign prod_green = PROD_W'(sum_green_r) * PROD_W'(rcp);
  assign prod_blue  = PROD_W'(sum_blue_r)  * PROD_W'(rcp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_out   <= prod_red[RECIP_SHIFT +: CH_W];
      out_green_out <= prod_green[RECIP_SHIFT +: CH_W];
      out_blue_out  <= prod_blue[RECIP_SHIFT +: CH_W];
      out_frame_end <= last_r;
    end
  end

endmodule
`default_nettype wire
